// ----- src/ati_pkg.sv -----
package ati_pkg;

  localparam int DEF_SLOTS = 64;

  localparam logic [31:0] EMPTY_MARK = 32'hFFFF_FFFF;

  localparam logic [2:0] REQ_SET_ROOT  = 3'd0;
  localparam logic [2:0] REQ_INS_LEFT  = 3'd1;
  localparam logic [2:0] REQ_INS_RIGHT = 3'd2;
  localparam logic [2:0] REQ_PREORDER  = 3'd3;
  localparam logic [2:0] REQ_INORDER   = 3'd4;
  localparam logic [2:0] REQ_POSTORDER = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ORD_PRE,
    ORD_IN,
    ORD_POST
  } order_t;

  typedef struct packed {
    logic               strobe;
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               last;
  } result_t;

endpackage

// ----- src/ati_store.sv -----
module ati_store import ati_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS,
  localparam int IW = $clog2(SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IW-1:0]     wr_addr,
  input  logic [31:0]       wr_data,
  input  logic              rd_en,
  input  logic [IW-1:0]     rd_addr,
  output logic [31:0]       rd_data,
  output logic              rd_valid
);

  logic [31:0]    mem [SLOTS];
  logic [SLOTS-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= rd_en && valid[rd_addr];
    end
  end

endmodule

// ----- src/ati_walker.sv -----
module ati_walker import ati_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS,
  localparam int IW = $clog2(SLOTS),
  localparam int AW = IW + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  order_t        go_order,
  output logic          busy,
  output logic          rd_en,
  output logic [IW-1:0] rd_addr,
  input  logic [31:0]   rd_data,
  input  logic          rd_valid,
  output result_t       res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EVAL,
    S_FLUSH
  } state_t;

  localparam logic [AW-1:0] SLOTS_A = AW'(SLOTS);
  localparam logic [AW-1:0] ROOT    = AW'(1);

  state_t        state;
  order_t        order;
  logic [AW-1:0] addr;
  logic          up;
  logic          right;
  logic [31:0]   pend;
  logic          have_pend;

  logic [AW-1:0] addr_next;
  logic          up_next;
  logic          right_next;
  logic          emit;
  logic          finish;
  logic          empty;
  logic          live;

  assign busy    = (state != S_IDLE);
  assign rd_en   = (state == S_FETCH) && (addr < SLOTS_A);
  assign rd_addr = addr[IW-1:0];
  assign live    = rd_valid && (rd_data != EMPTY_MARK);

  // stackless walk: down into a slot, or up into the parent from one side
  always_comb begin
    addr_next  = addr;
    up_next    = up;
    right_next = right;
    emit       = 1'b0;
    finish     = 1'b0;
    empty      = 1'b0;
    if (!up) begin
      if (live) begin
        emit      = (order == ORD_PRE);
        addr_next = {addr[AW-2:0], 1'b0};
      end else if (addr == ROOT) begin
        empty = 1'b1;
      end else begin
        up_next    = 1'b1;
        right_next = addr[0];
        addr_next  = addr >> 1;
      end
    end else if (!right) begin
      emit      = (order == ORD_IN);
      addr_next = {addr[AW-2:0], 1'b1};
      up_next   = 1'b0;
    end else begin
      emit = (order == ORD_POST);
      if (addr == ROOT) begin
        finish = 1'b1;
      end else begin
        right_next = addr[0];
        addr_next  = addr >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res.strobe <= 1'b0;
      have_pend  <= 1'b0;
    end else begin
      res.strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            order     <= go_order;
            addr      <= ROOT;
            up        <= 1'b0;
            right     <= 1'b0;
            have_pend <= 1'b0;
            state     <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (empty) begin
            res.strobe <= 1'b1;
            res.value  <= '0;
            res.status <= ST_EMPTY;
            res.last   <= 1'b1;
            state      <= S_IDLE;
          end else begin
            // hold one value back so the final one can carry last
            if (emit) begin
              if (have_pend) begin
                res.strobe <= 1'b1;
                res.value  <= pend;
                res.status <= ST_OK;
                res.last   <= 1'b0;
              end
              pend      <= rd_data;
              have_pend <= 1'b1;
            end
            addr  <= addr_next;
            up    <= up_next;
            right <= right_next;
            state <= finish ? S_FLUSH : S_FETCH;
          end
        end
        S_FLUSH: begin
          res.strobe <= 1'b1;
          res.value  <= pend;
          res.status <= ST_OK;
          res.last   <= 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/array_tree_insert_and_traverse_top.sv -----
// Binary tree kept in SLOTS slots, children of slot p at 2p and 2p+1, root in
// slot 1, all slots empty after reset. An item is taken when start is high and
// busy is low. Set root and inserts leave busy low, and the single reply
// appears on the next cycle. A walk raises busy and runs the address
// sequencer step by step, each step a store read (S_FETCH) and then an
// evaluate (S_EVAL), a step being a visit to a slot or a return to it from
// one side, with a step also for each empty or out-of-range probe; S_FLUSH
// then sends the held final value, and a walk of an empty tree gives a
// single empty reply. Results come out at most one per cycle on
// result_strobe with last on the final one, and must be taken when shown:
// the receiver cannot stall the block.
module array_tree_insert_and_traverse_top import ati_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS,
  localparam int IW = $clog2(SLOTS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         req_type,
  input  logic [5:0]         parent_index,
  input  logic signed [31:0] node_value,
  output logic               result_strobe,
  output logic signed [31:0] out_value,
  output logic [1:0]         status,
  output logic               last
);

  localparam logic [6:0] SLOTS_C = 7'(SLOTS);

  logic          accept;
  logic          is_ins;
  logic          is_walk;
  logic [6:0]    child;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  order_t        walk_order;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic          rd_valid;
  logic          walk_busy;
  result_t       wres;
  result_t       rep;

  assign accept  = start && !busy;
  assign is_ins  = (req_type == REQ_INS_LEFT) || (req_type == REQ_INS_RIGHT);
  assign is_walk = (req_type == REQ_PREORDER) || (req_type == REQ_INORDER) ||
                   (req_type == REQ_POSTORDER);
  assign child   = {parent_index, (req_type == REQ_INS_RIGHT)};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IW'(1);
    if (accept) begin
      if (req_type == REQ_SET_ROOT) begin
        wr_en = 1'b1;
      end else if (is_ins && (child < SLOTS_C)) begin
        wr_en   = 1'b1;
        wr_addr = child[IW-1:0];
      end
    end
  end

  always_comb begin
    unique case (req_type)
      REQ_INORDER:   walk_order = ORD_IN;
      REQ_POSTORDER: walk_order = ORD_POST;
      default:       walk_order = ORD_PRE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep.strobe <= 1'b0;
    end else begin
      rep.strobe <= accept && (is_ins || (req_type == REQ_SET_ROOT));
      rep.value  <= '0;
      rep.last   <= 1'b1;
      rep.status <= (is_ins && !(child < SLOTS_C)) ? ST_RANGE : ST_OK;
    end
  end

  ati_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (node_value),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  ati_walker #(
    .SLOTS (SLOTS)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .go       (accept && is_walk),
    .go_order (walk_order),
    .busy     (walk_busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .res      (wres)
  );

  assign busy          = walk_busy;
  assign result_strobe = wres.strobe || rep.strobe;
  assign out_value     = wres.strobe ? wres.value  : rep.value;
  assign status        = wres.strobe ? wres.status : rep.status;
  assign last          = wres.strobe ? wres.last   : rep.last;

endmodule

// ----- tb/sv/tree_walk_checker.sv -----
module tree_walk_checker import ati_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         req_type,
  input  logic [5:0]         parent_index,
  input  logic signed [31:0] node_value,
  input  logic               result_strobe,
  input  logic signed [31:0] out_value,
  input  logic [1:0]         status,
  input  logic               last,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int SLOT_COUNT = DEF_SLOTS;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               last;
  } tree_reply_t;

  typedef enum int {
    AT_NODE,
    AFTER_LEFT,
    AFTER_RIGHT
  } walk_step_t;

  logic [31:0] slot_mirror [SLOT_COUNT];
  tree_reply_t replies_due [$];
  int          errors = 0;

  function automatic tree_reply_t make_reply(logic signed [31:0] value, logic [1:0] code,
                                             logic is_last);
    tree_reply_t r;
    r.value = value;
    r.status = code;
    r.last = is_last;
    return r;
  endfunction

  function automatic bit slot_holds_node(int idx);
    return idx < SLOT_COUNT && slot_mirror[idx] != EMPTY_MARK;
  endfunction

  task automatic model_request(input logic [2:0] req, input logic [5:0] parent,
                               input logic signed [31:0] value);
    int          child;
    int          here;
    int          depth;
    int          idx_stack [8];
    walk_step_t  step_stack [8];
    order_t      order;
    tree_reply_t walk_out [$];
    case (req)
      REQ_SET_ROOT: begin
        slot_mirror[1] = value;
        replies_due.push_back(make_reply(32'sd0, ST_OK, 1'b1));
      end
      REQ_INS_LEFT, REQ_INS_RIGHT: begin
        child = 2 * int'(parent) + ((req == REQ_INS_RIGHT) ? 1 : 0);
        if (child < SLOT_COUNT) begin
          slot_mirror[child] = value;
          replies_due.push_back(make_reply(32'sd0, ST_OK, 1'b1));
        end else begin
          replies_due.push_back(make_reply(32'sd0, ST_RANGE, 1'b1));
        end
      end
      REQ_PREORDER, REQ_INORDER, REQ_POSTORDER: begin
        if (!slot_holds_node(1)) begin
          replies_due.push_back(make_reply(32'sd0, ST_EMPTY, 1'b1));
        end else begin
          order = order_t'(req - REQ_PREORDER);
          depth = 1;
          idx_stack[0] = 1;
          step_stack[0] = AT_NODE;
          while (depth > 0) begin
            here = idx_stack[depth-1];
            case (step_stack[depth-1])
              AT_NODE: begin
                if (!slot_holds_node(here)) begin
                  depth--;
                end else begin
                  if (order == ORD_PRE) walk_out.push_back(make_reply(slot_mirror[here], ST_OK, 1'b0));
                  step_stack[depth-1] = AFTER_LEFT;
                  idx_stack[depth] = 2 * here;
                  step_stack[depth] = AT_NODE;
                  depth++;
                end
              end
              AFTER_LEFT: begin
                if (order == ORD_IN) walk_out.push_back(make_reply(slot_mirror[here], ST_OK, 1'b0));
                step_stack[depth-1] = AFTER_RIGHT;
                idx_stack[depth] = 2 * here + 1;
                step_stack[depth] = AT_NODE;
                depth++;
              end
              default: begin
                if (order == ORD_POST) walk_out.push_back(make_reply(slot_mirror[here], ST_OK, 1'b0));
                depth--;
              end
            endcase
          end
          walk_out[walk_out.size()-1].last = 1'b1;
          foreach (walk_out[i]) replies_due.push_back(walk_out[i]);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    tree_reply_t due;
    if (rst) begin
      foreach (slot_mirror[i]) slot_mirror[i] = EMPTY_MARK;
      replies_due.delete();
    end else begin
      if (result_strobe) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result value %0d status %0d last %0b", $time,
                   out_value, status, last);
          errors++;
        end else begin
          due = replies_due.pop_front();
          if (out_value !== due.value) begin
            $display("%0t: out_value expected %0d got %0d", $time, due.value, out_value);
            errors++;
          end
          if (status !== due.status) begin
            $display("%0t: status expected %0d got %0d", $time, due.status, status);
            errors++;
          end
          if (last !== due.last) begin
            $display("%0t: last expected %0b got %0b", $time, due.last, last);
            errors++;
          end
        end
      end
      if (start && !busy) model_request(req_type, parent_index, node_value);
    end
    fail_count <= errors;
    pending_count <= replies_due.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import ati_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 120;
  localparam logic [2:0] REQ_FIRST_SPARE = REQ_POSTORDER + 3'd1;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         req_type;
  logic [5:0]         parent_index;
  logic signed [31:0] node_value;
  logic               result_strobe;
  logic signed [31:0] out_value;
  logic [1:0]         status;
  logic               last;
  int                 fail_count;
  int                 pending_count;
  int                 quiet_cycles = 0;
  int                 idle_pct = 0;

  array_tree_insert_and_traverse_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .parent_index  (parent_index),
    .node_value    (node_value),
    .result_strobe (result_strobe),
    .out_value     (out_value),
    .status        (status),
    .last          (last)
  );

  tree_walk_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .parent_index  (parent_index),
    .node_value    (node_value),
    .result_strobe (result_strobe),
    .out_value     (out_value),
    .status        (status),
    .last          (last),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic sender_pause();
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(300, 20) : $urandom_range(6, 1);
      start <= 1'b0;
      req_type <= 3'($urandom);
      parent_index <= 6'($urandom);
      node_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue(input logic [2:0] req, input logic [5:0] parent,
                       input logic signed [31:0] value);
    sender_pause();
    start <= 1'b1;
    req_type <= req;
    parent_index <= parent;
    node_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic issue_random(output bit counted);
    int                 pick;
    int                 spread;
    logic [2:0]         req;
    logic [5:0]         parent;
    logic signed [31:0] value;
    pick = $urandom_range(99);
    case ($urandom_range(15))
      0: value = -32'sd1;
      1: value = 32'sh8000_0000;
      2: value = 32'sh7fff_ffff;
      3: value = 32'sd0;
      default: value = $urandom;
    endcase
    spread = $urandom_range(19);
    if (spread == 0) parent = 6'd0;
    else if (spread < 4) parent = 6'($urandom_range(63, 32));
    else parent = 6'($urandom_range(31, 1));
    if (pick < 6) begin
      req = REQ_SET_ROOT;
      if ($urandom_range(2) == 0) value = -32'sd1;
    end else if (pick < 56) begin
      req = ($urandom_range(1) == 1) ? REQ_INS_RIGHT : REQ_INS_LEFT;
    end else if (pick < 95) begin
      req = REQ_PREORDER + 3'($urandom_range(2));
    end else begin
      req = REQ_FIRST_SPARE + 3'($urandom_range(1));
    end
    counted = (req <= REQ_POSTORDER);
    issue(req, parent, value);
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int idle_plan [4];
    int sent;
    bit counted;
    idle_plan = '{0, 68, 0, 19};
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_SET_ROOT;
    parent_index = 6'd0;
    node_value = 32'sd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    issue(REQ_PREORDER, 6'd0, 32'sd0);
    issue(REQ_INORDER, 6'd63, 32'sd0);
    issue(REQ_POSTORDER, 6'd0, 32'sd0);
    issue(REQ_SET_ROOT, 6'd0, 32'sd10);
    issue(REQ_INS_LEFT, 6'd1, 32'sh8000_0000);
    issue(REQ_INS_RIGHT, 6'd1, 32'sh7fff_ffff);
    issue(REQ_INS_LEFT, 6'd2, 32'sd0);
    issue(REQ_INS_RIGHT, 6'd3, -32'sd2);
    issue(REQ_INS_LEFT, 6'd31, 32'sd5);
    issue(REQ_INS_RIGHT, 6'd31, 32'sd6);
    issue(REQ_INS_LEFT, 6'd32, 32'sd7);
    issue(REQ_INS_RIGHT, 6'd63, 32'sd8);
    issue(REQ_INS_LEFT, 6'd0, 32'sd77);
    issue(REQ_PREORDER, 6'd0, 32'sd0);
    issue(REQ_INORDER, 6'd0, 32'sd0);
    issue(REQ_POSTORDER, 6'd0, 32'sd0);
    issue(REQ_INS_RIGHT, 6'd0, 32'sd100);
    issue(REQ_PREORDER, 6'd0, 32'sd0);
    issue(REQ_INS_LEFT, 6'd1, -32'sd1);
    issue(REQ_INORDER, 6'd0, 32'sd0);
    issue(REQ_FIRST_SPARE, 6'd1, 32'sd3);
    issue(REQ_FIRST_SPARE + 3'd1, 6'd2, 32'sd4);
    issue(REQ_SET_ROOT, 6'd0, -32'sd1);
    issue(REQ_POSTORDER, 6'd0, 32'sd0);

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_plan[p];
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        issue_random(counted);
        if (counted) sent++;
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
